>>> rtl/bsram_pkg.sv
// Shared types and constants for the battery-backed SRAM bus device.
// No dependencies; every other file of the block but bsram_ram imports this package.
package bsram_pkg;

    localparam int OPCODE_W = 3;
    localparam int OFS_W    = 16;
    localparam int DATA_W   = 16;
    localparam int PC_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [OPCODE_W-1:0] {
        OP_READ_BYTE  = 3'd0,
        OP_READ_WORD  = 3'd1,
        OP_WRITE_BYTE = 3'd2,
        OP_WRITE_WORD = 3'd3,
        OP_PEEK_BYTE  = 3'd4,
        OP_BOOT_COUNT = 3'd5,
        OP_SET_SWITCH = 3'd6
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_BLOCKS    = 2'd0,
        CFG_WRITE_ENABLE   = 2'd1,
        CFG_SWITCH_PROTECT = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    // Boot ROM write of the memory switch that protection suppresses.
    localparam logic [PC_W-1:0]  PROTECT_PC  = 24'hFF03A8;
    localparam logic [OFS_W-1:0] PROTECT_OFS = 16'h0009;
    localparam logic [7:0]       PROTECT_VAL = 8'h10;

    // Big-endian 32-bit boot counter: high word at 0x44, low word at 0x46.
    localparam logic [OFS_W-1:0] BOOT_OFS = 16'h0044;

    localparam logic [DATA_W-1:0] FAULT_DATA = 16'h00FF;
    localparam logic [DATA_W-1:0] ERASED     = 16'hFFFF;

endpackage

>>> rtl/bsram_req_if.sv
// Request channel of the SRAM bus device: one bus access per beat.
// Depends on bsram_pkg for field widths.
interface bsram_req_if import bsram_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [OFS_W-1:0]    byte_offset;
    logic [DATA_W-1:0]   write_data;
    logic [PC_W-1:0]     cpu_pc;

    modport source (output valid, opcode, byte_offset, write_data, cpu_pc, input ready);
    modport sink   (input valid, opcode, byte_offset, write_data, cpu_pc, output ready);
endinterface

>>> rtl/bsram_rsp_if.sv
// Response channel of the SRAM bus device: one result per beat.
// Depends on bsram_pkg for field widths.
interface bsram_rsp_if import bsram_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              bus_error;
    logic              wait_charged;
    logic              modified;

    modport source (output valid, read_data, bus_error, wait_charged, modified, input ready);
    modport sink   (input valid, read_data, bus_error, wait_charged, modified, output ready);
endinterface

>>> rtl/bsram_cfg_if.sv
// Configuration write channel of the SRAM bus device.
// Depends on bsram_pkg for index and data widths.
interface bsram_cfg_if import bsram_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/bsram_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bsram_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/battery_sram_bus_device_top.sv
// Top level of the battery-backed SRAM bus device.
// Depends on bsram_pkg, the three channel interfaces and bsram_ram.

// The device takes one bus access per clock while the response channel is not
// stalled; each accepted request beat is held in the stage-one register and its
// result is loaded into the response register when stage one moves on, since the
// word is read from the single-read-port memory at the accepting edge and merged
// and written back as it leaves stage one. Back-to-back accesses to the same
// word are forwarded around the memory. The two words of the boot counter live
// in flip-flops, so a boot count increments all 32 bits in a single update.
// After reset a clearing pass fills every memory word with ones; no request beat
// is accepted during it, while configuration writes are taken at any time.
module battery_sram_bus_device_top import bsram_pkg::*; #(
    parameter int WORD_DEPTH = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    bsram_req_if.sink   req,
    bsram_rsp_if.source rsp,
    bsram_cfg_if.sink   cfg
);

    localparam int AW = $clog2(WORD_DEPTH);
    localparam logic [16:0] DEPTH_1   = 17'(WORD_DEPTH);
    localparam logic [16:0] DEPTH_2   = 17'(2 * WORD_DEPTH);
    localparam logic [16:0] DEPTH_3   = 17'(3 * WORD_DEPTH);
    localparam logic [16:0] OFS_LIMIT = 17'(2 * WORD_DEPTH);
    localparam logic [AW-1:0] BOOT_HI_IDX = AW'(BOOT_OFS >> 1);
    localparam logic [AW-1:0] BOOT_LO_IDX = AW'((BOOT_OFS >> 1) + 16'd1);
    localparam logic [AW-1:0] LAST_IDX    = AW'(WORD_DEPTH - 1);

    // Configuration registers.
    logic [2:0] size_reg;
    logic       we_reg;
    logic       prot_reg;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_cnt_reg;

    // Stage one: accepted request, with the memory word read in parallel.
    logic              s1_valid_reg;
    op_t               s1_op_reg;
    logic [OFS_W-1:0]  s1_ofs_reg;
    logic [DATA_W-1:0] s1_data_reg;
    logic [AW-1:0]     s1_idx_reg;
    logic              s1_block_reg;

    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_idx_reg;
    logic [DATA_W-1:0] fwd_data_reg;

    logic [DATA_W-1:0] boot_hi_reg, boot_hi_next;
    logic [DATA_W-1:0] boot_lo_reg, boot_lo_next;
    logic              dirty_reg, dirty_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic              out_berr_reg, out_berr_next;
    logic              out_wait_reg, out_wait_next;

    logic              clearing;
    logic              in_fire;
    logic              s1_fire;
    logic [OFS_W-1:0]  in_ofs;
    logic [16:0]       in_word;
    logic [AW-1:0]     in_idx;
    logic              in_block;

    logic [2:0]        size_eff;
    logic              in_range;
    logic              shadow_hit;
    logic [DATA_W-1:0] old_word;
    logic [DATA_W-1:0] new_word;
    logic [7:0]        old_byte;
    logic              upd;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic [AW-1:0]     ram_rd_addr;
    logic [DATA_W-1:0] ram_q;

    assign clearing  = (state_reg == ST_CLEAR);
    assign s1_fire   = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !clearing && (!s1_valid_reg || s1_fire);
    assign in_fire   = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    // Set switch addresses only the low 256 bytes.
    assign in_ofs = (op_t'(req.opcode) == OP_SET_SWITCH) ? {8'h00, req.byte_offset[7:0]}
                                                         : req.byte_offset;
    assign in_word = {2'b00, in_ofs[OFS_W-1:1]};

    // Word index modulo the depth; the word number is below four times the depth.
    always_comb
    begin
        priority if (in_word >= DEPTH_3)
        begin
            in_idx = AW'(in_word - DEPTH_3);
        end
        else if (in_word >= DEPTH_2)
        begin
            in_idx = AW'(in_word - DEPTH_2);
        end
        else if (in_word >= DEPTH_1)
        begin
            in_idx = AW'(in_word - DEPTH_1);
        end
        else
        begin
            in_idx = AW'(in_word);
        end
    end

    assign in_block = (req.byte_offset == PROTECT_OFS) && (req.write_data[7:0] == PROTECT_VAL)
                   && (req.cpu_pc == PROTECT_PC);

    assign ram_rd_addr = in_fire ? in_idx : s1_idx_reg;

    always_comb
    begin
        if (clearing)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = ERASED;
        end
        else
        begin
            ram_wr_en   = s1_fire && upd && !shadow_hit;
            ram_wr_addr = s1_idx_reg;
            ram_wr_data = new_word;
        end
    end

    bsram_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WORD_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        if (size_reg == 3'd0)
        begin
            size_eff = 3'd1;
        end
        else if (size_reg > 3'd4)
        begin
            size_eff = 3'd4;
        end
        else
        begin
            size_eff = size_reg;
        end
    end

    assign in_range = ({1'b0, s1_ofs_reg[15:14]} < size_eff) && ({1'b0, s1_ofs_reg} < OFS_LIMIT);

    assign shadow_hit = (s1_idx_reg == BOOT_HI_IDX) || (s1_idx_reg == BOOT_LO_IDX);

    always_comb
    begin
        if (s1_idx_reg == BOOT_HI_IDX)
        begin
            old_word = boot_hi_reg;
        end
        else if (s1_idx_reg == BOOT_LO_IDX)
        begin
            old_word = boot_lo_reg;
        end
        else if (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg))
        begin
            old_word = fwd_data_reg;
        end
        else
        begin
            old_word = ram_q;
        end
    end

    assign old_byte = s1_ofs_reg[0] ? old_word[7:0] : old_word[15:8];

    // Result of one access, plus the merged word and whether it is written.
    always_comb
    begin
        out_rd_next   = FAULT_DATA;
        out_berr_next = 1'b0;
        out_wait_next = 1'b0;
        new_word      = old_word;
        upd           = 1'b0;
        boot_hi_next  = boot_hi_reg;
        boot_lo_next  = boot_lo_reg;
        dirty_next    = dirty_reg;
        if (s1_op_reg == OP_WRITE_WORD)
        begin
            new_word = s1_data_reg;
        end
        else if (s1_ofs_reg[0])
        begin
            new_word = {old_word[15:8], s1_data_reg[7:0]};
        end
        else
        begin
            new_word = {s1_data_reg[7:0], old_word[7:0]};
        end
        unique case (s1_op_reg)
            OP_READ_BYTE, OP_READ_WORD:
            begin
                if (!in_range)
                begin
                    out_berr_next = 1'b1;
                end
                else
                begin
                    out_wait_next = 1'b1;
                    out_rd_next   = (s1_op_reg == OP_READ_WORD) ? old_word : {8'h00, old_byte};
                end
            end
            OP_WRITE_BYTE, OP_WRITE_WORD:
            begin
                if (!in_range)
                begin
                    out_berr_next = 1'b1;
                end
                else if (we_reg)
                begin
                    out_wait_next = 1'b1;
                    upd = !(s1_op_reg == OP_WRITE_BYTE && s1_block_reg && prot_reg);
                end
            end
            OP_PEEK_BYTE:
            begin
                if (in_range)
                begin
                    out_rd_next = {8'h00, old_byte};
                end
            end
            OP_BOOT_COUNT:
            begin
                dirty_next = 1'b1;
                if (boot_lo_reg != ERASED)
                begin
                    boot_lo_next = boot_lo_reg + 16'd1;
                end
                else
                begin
                    boot_lo_next = '0;
                    boot_hi_next = boot_hi_reg + 16'd1;
                end
            end
            OP_SET_SWITCH:
            begin
                upd = 1'b1;
            end
            default:
            begin
                upd = 1'b0;
            end
        endcase
        // A write of the value already stored changes nothing.
        if (upd && (new_word != old_word))
        begin
            dirty_next = 1'b1;
            if (s1_idx_reg == BOOT_HI_IDX)
            begin
                boot_hi_next = new_word;
            end
            else if (s1_idx_reg == BOOT_LO_IDX)
            begin
                boot_lo_next = new_word;
            end
        end
        else
        begin
            upd = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            size_reg      <= 3'd1;
            we_reg        <= 1'b0;
            prot_reg      <= 1'b1;
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            dirty_reg     <= 1'b0;
            boot_hi_reg   <= ERASED;
            boot_lo_reg   <= ERASED;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    CFG_SIZE_BLOCKS:    size_reg <= cfg.data;
                    CFG_WRITE_ENABLE:   we_reg   <= cfg.data[0];
                    CFG_SWITCH_PROTECT: prot_reg <= cfg.data[0];
                    default:            size_reg <= size_reg;
                endcase
            end
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
                dirty_reg     <= dirty_next;
                boot_hi_reg   <= boot_hi_next;
                boot_lo_reg   <= boot_lo_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_wr_en && !clearing)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= op_t'(req.opcode);
            s1_ofs_reg   <= in_ofs;
            s1_data_reg  <= req.write_data;
            s1_idx_reg   <= in_idx;
            s1_block_reg <= in_block;
        end
        if (s1_fire)
        begin
            out_rd_reg   <= out_rd_next;
            out_berr_reg <= out_berr_next;
            out_wait_reg <= out_wait_next;
        end
        // Latest memory write, so that the next beat sees it before the memory does.
        if (ram_wr_en && !clearing)
        begin
            fwd_idx_reg  <= ram_wr_addr;
            fwd_data_reg <= ram_wr_data;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = out_rd_reg;
    assign rsp.bus_error    = out_berr_reg;
    assign rsp.wait_charged = out_wait_reg;
    assign rsp.modified     = dirty_reg;

    a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !req.ready && !s1_valid_reg)
        else $error("request taken during the clearing pass");

    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg |=> dirty_reg)
        else $error("modified flag cleared without reset");

    a_fault_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_berr_reg |-> out_rd_reg == FAULT_DATA && !out_wait_reg)
        else $error("bus error result carries data or a wait state");

    a_boot_sets_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_op_reg == OP_BOOT_COUNT |=> dirty_reg)
        else $error("boot count did not mark the contents modified");

    a_no_shadow_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en && !clearing |-> !shadow_hit)
        else $error("boot counter word written to the memory array");

endmodule
